FILE: rtl/pff_pkg.sv
// ---------------------------------------------------------------------------
// pff_pkg: shared types and constants of the Pareto front filter
// Field widths, default parameter values, sequencer states and the control
// word that passes from the sequencer to the datapath.
// ---------------------------------------------------------------------------
package pff_pkg;

	localparam int COST_W        = 32;
	localparam int GAIN_W        = 32;
	localparam int TAG_W         = 64;
	localparam int TDATA_W       = COST_W + GAIN_W + TAG_W;
	localparam int MAX_ITEMS_DEF = 64;
	localparam int OBJ_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_CAPTURE,
		ST_SCAN,
		ST_DECIDE,
		ST_FLUSH
	} pff_state_t;

	typedef struct packed {
		logic cap_cand;
		logic load_pend;
		logic push_out;
		logic push_last;
		logic overflow;
	} pff_ctl_t;

endpackage

FILE: rtl/pff_ram.sv
// ---------------------------------------------------------------------------
// pff_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ---------------------------------------------------------------------------
module pff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/pff_dom_unit.sv
// ---------------------------------------------------------------------------
// pff_dom_unit: shared dominance comparator
// Flags when the other item dominates the candidate: cost no higher, gain no
// lower, and strictly better in at least one of the two.
// ---------------------------------------------------------------------------
module pff_dom_unit #(
	parameter int W = 32
) (
	input  logic [W-1:0] cand_cost,
	input  logic [W-1:0] cand_gain,
	input  logic [W-1:0] other_cost,
	input  logic [W-1:0] other_gain,
	output logic         beats
);

	logic cost_le, gain_ge, cost_lt, gain_gt;

	assign cost_le = other_cost <= cand_cost;
	assign gain_ge = other_gain >= cand_gain;
	assign cost_lt = other_cost <  cand_cost;
	assign gain_gt = other_gain >  cand_gain;
	assign beats   = cost_le && gain_ge && (cost_lt || gain_gt);

endmodule

FILE: rtl/pff_ctrl.sv
// ---------------------------------------------------------------------------
// pff_ctrl: load and scan sequencer
// Stores the set, then per stored item sweeps the stored items through the shared
// comparator until one beats it or all are seen, and decides if the item is kept.
// ---------------------------------------------------------------------------
module pff_ctrl #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_last,
	input  logic                         out_free,
	input  logic                         beats,
	output logic                         in_ready,
	output logic                         wr_en,
	output logic [$clog2(MAX_ITEMS)-1:0] waddr,
	output logic [$clog2(MAX_ITEMS)-1:0] raddr,
	output pff_pkg::pff_ctl_t            ctl
);
	import pff_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = $clog2(MAX_ITEMS);

	pff_state_t    state_q, state_d;
	logic [CW-1:0] cnt_q, i_q, j_q;
	logic [CW-1:0] i_next;
	logic          dom_q, pend_vld_q, ovf_q;
	logic          accept, has_room, dom_now, scan_done, adv;

	assign accept    = in_valid && in_ready;
	assign has_room  = cnt_q < CW'(MAX_ITEMS);
	assign dom_now   = dom_q || beats;
	// The entry compared in a scan cycle is the one addressed in the cycle before, as the RAM read is registered.
	assign scan_done = dom_now || (j_q == cnt_q);
	assign adv       = dom_q || !pend_vld_q || out_free;
	assign i_next    = CW'(i_q + 1'b1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && in_last) state_d = ST_FETCH;
			end
			ST_FETCH:   state_d = ST_CAPTURE;
			ST_CAPTURE: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (adv) state_d = (i_next == cnt_q) ? ST_FLUSH : ST_FETCH;
			end
			ST_FLUSH: begin
				if (out_free || !pend_vld_q) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		wr_en         = 1'b0;
		waddr         = cnt_q[AW-1:0];
		raddr         = j_q[AW-1:0];
		ctl           = '0;
		ctl.overflow  = ovf_q;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				wr_en    = accept && has_room;
			end
			ST_FETCH:   raddr = i_q[AW-1:0];
			ST_CAPTURE: begin
				ctl.cap_cand = 1'b1;
				raddr        = '0;
			end
			ST_SCAN: ;
			ST_DECIDE: begin
				ctl.load_pend = !dom_q && (!pend_vld_q || out_free);
				ctl.push_out  = !dom_q && pend_vld_q && out_free;
			end
			ST_FLUSH: begin
				ctl.push_out  = pend_vld_q && out_free;
				ctl.push_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			cnt_q      <= '0;
			i_q        <= '0;
			j_q        <= '0;
			dom_q      <= 1'b0;
			pend_vld_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (has_room) cnt_q <= CW'(cnt_q + 1'b1);
						else          ovf_q <= 1'b1;
					end
					i_q <= '0;
				end
				ST_FETCH: ;
				ST_CAPTURE: begin
					j_q   <= CW'(1);
					dom_q <= 1'b0;
				end
				ST_SCAN: begin
					j_q   <= CW'(j_q + 1'b1);
					dom_q <= dom_now;
				end
				ST_DECIDE: begin
					if (adv) i_q <= i_next;
					if (ctl.load_pend) pend_vld_q <= 1'b1;
				end
				ST_FLUSH: begin
					if (out_free || !pend_vld_q) begin
						cnt_q      <= '0;
						ovf_q      <= 1'b0;
						pend_vld_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/pareto_front_filter_top.sv
// The front of n stored items is complete once the scan after the word carrying tlast ends;
// the scan waits while the output is stalled, and earlier words of the front leave sooner.
// Throughput: one input word per cycle while a set loads; the next set is taken only
// once the single comparator has swept the RAM for each stored item of the last one.
// Reset: arst_n clears the sequencer, item count, overflow flag and output
// valid; the item RAM is not cleared.
// ---------------------------------------------------------------------------
// pareto_front_filter_top: two-objective Pareto front filter
// Loads a set of items into RAM, then emits in input order every item that no
// other stored item dominates. Items beyond capacity are dropped and flagged.
// ---------------------------------------------------------------------------
module pareto_front_filter_top #(
	parameter int MAX_ITEMS = pff_pkg::MAX_ITEMS_DEF,
	parameter int OBJ_WIDTH = pff_pkg::OBJ_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// cost_value [31:0], gain_value [63:32], item_tag [127:64]
	input  logic [pff_pkg::TDATA_W-1:0] s_axis_tdata,
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// front_cost [31:0], front_gain [63:32], front_tag [127:64]
	output logic [pff_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                        m_axis_tlast,
	// capacity_overflow [0]
	output logic                        m_axis_tuser
);
	import pff_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int SW = (OBJ_WIDTH < COST_W) ? OBJ_WIDTH : COST_W;
	localparam int RW = 2 * SW + TAG_W;

	pff_ctl_t       ctl;
	logic           wr_en, beats, out_free;
	logic [AW-1:0]  waddr, raddr;
	logic [RW-1:0]  wdata, rdata;
	logic [SW-1:0]  rd_cost, rd_gain;
	logic [SW-1:0]  cand_cost_q, cand_gain_q, pend_cost_q, pend_gain_q;
	logic [TAG_W-1:0] cand_tag_q, pend_tag_q;
	logic           out_vld_q, out_last_q, out_ovf_q;
	logic [TDATA_W-1:0] out_data_q;

	// Objectives are kept on their low SW bits only, the lesser of OBJ_WIDTH and 32.
	assign wdata = {s_axis_tdata[COST_W+GAIN_W +: TAG_W],
	                s_axis_tdata[COST_W +: SW],
	                s_axis_tdata[0 +: SW]};
	assign rd_cost = rdata[0 +: SW];
	assign rd_gain = rdata[SW +: SW];

	assign out_free = !out_vld_q || m_axis_tready;

	pff_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_ITEMS)
	) u_ram (
		.clk  (clk),
		.wr_en(wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	pff_dom_unit #(
		.W(SW)
	) u_dom (
		.cand_cost (cand_cost_q),
		.cand_gain (cand_gain_q),
		.other_cost(rd_cost),
		.other_gain(rd_gain),
		.beats     (beats)
	);

	pff_ctrl #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_last (s_axis_tlast),
		.out_free(out_free),
		.beats   (beats),
		.in_ready(s_axis_tready),
		.wr_en   (wr_en),
		.waddr   (waddr),
		.raddr   (raddr),
		.ctl     (ctl)
	);

	always_ff @(posedge clk) begin
		if (ctl.cap_cand) begin
			cand_cost_q <= rd_cost;
			cand_gain_q <= rd_gain;
			cand_tag_q  <= rdata[2*SW +: TAG_W];
		end
		// A kept item waits here until the next kept item, or the end of the
		// scan, tells whether it is the last word of the front.
		if (ctl.load_pend) begin
			pend_cost_q <= cand_cost_q;
			pend_gain_q <= cand_gain_q;
			pend_tag_q  <= cand_tag_q;
		end
		if (ctl.push_out) begin
			out_data_q <= {pend_tag_q, GAIN_W'(pend_gain_q), COST_W'(pend_cost_q)};
			out_last_q <= ctl.push_last;
			out_ovf_q  <= ctl.overflow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.push_out) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_ovf_q;

endmodule

FILE: rtl/pff_checker.sv
// ---------------------------------------------------------------------------
// pff_checker: port-level checks for the Pareto front filter
// Watches the stream ports of the top level over time.
// ---------------------------------------------------------------------------
module pff_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        s_axis_tlast,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [pff_pkg::TDATA_W-1:0] m_axis_tdata,
	input logic                        m_axis_tlast,
	input logic                        m_axis_tuser
);

	// The block stops taking words once a set is closed.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input still ready after the closing word of a set");

	// Front words are produced only while the scan runs.
	a_out_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("front word appeared while the block was loading");

	// The overflow flag is the same on every word of one front.
	a_user_steady: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			!m_axis_tvalid || $stable(m_axis_tuser))
		else $error("overflow flag changed within a front");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output word changed");

endmodule

bind pareto_front_filter_top pff_checker u_pff_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tlast (s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast),
	.m_axis_tuser (m_axis_tuser)
);
